// ===== design/tmar_pkg.sv =====
`default_nettype none

package tmar_pkg;

    localparam int PIX_W        = 8;
    localparam int CHAR_W       = 7;
    localparam int SUM_W        = 18;
    localparam int SIDE_W       = 6;
    localparam int TCNT_W       = 9;
    localparam int COL_W        = 5;
    localparam int SLOT_W       = 8;
    localparam int DVS_W        = 11;
    localparam int MEAN_W       = 8;
    localparam int STEP_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;

    localparam int TILE_SLOTS   = 256;
    localparam int MAX_SIDE     = 32;
    localparam int MAX_TILES    = 256;
    localparam int MAX_ROWS     = 256;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIDE_W-1:0] SIDE_RESET   = 6'd12;
    localparam logic [TCNT_W-1:0] ACROSS_RESET = 9'd100;
    localparam logic [TCNT_W-1:0] DOWN_RESET   = 9'd56;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [SIDE_W-1:0] side;
        logic              row_end;
        logic              frame_last;
    } t_tile_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SAT,
        ST_DIV,
        ST_CHAR,
        ST_NL
    } t_back_state;

    // ramp index is floor(mean * 9 / 255), found by its thresholds
    function automatic logic [CHAR_W-1:0] ramp_char(input logic [MEAN_W-1:0] mean);
        logic [CHAR_W-1:0] code;
        code = 7'd32;
        if (mean >= 8'd29)  code = 7'd46;
        if (mean >= 8'd57)  code = 7'd58;
        if (mean >= 8'd85)  code = 7'd45;
        if (mean >= 8'd114) code = 7'd61;
        if (mean >= 8'd142) code = 7'd43;
        if (mean >= 8'd170) code = 7'd42;
        if (mean >= 8'd199) code = 7'd35;
        if (mean >= 8'd227) code = 7'd37;
        if (mean == 8'd255) code = 7'd64;
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== design/tmar_ram.sv =====
`default_nettype none

module tmar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/tmar_front.sv =====
`default_nettype none

module tmar_front
    import tmar_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [PIX_W-1:0]  i_pixel,
    input  wire logic [SIDE_W-1:0] i_cell_side,
    input  wire logic [TCNT_W-1:0] i_tiles_across,
    input  wire logic [TCNT_W-1:0] i_tiles_down,
    input  wire logic [QCNT_W-1:0] i_q_count,
    output logic                   o_q_push,
    output t_tile_word             o_q_word
);

    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_tcol;
    logic [COL_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_trow;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [SLOT_W-1:0] r_s1_slot;
    logic              r_s1_first;
    logic              r_s1_tile_end;
    logic              r_s1_row_end;
    logic              r_s1_frame_last;
    logic [SIDE_W-1:0] r_s1_side;
    logic              r_s1_fwd;
    logic [SUM_W-1:0]  r_s1_fwd_sum;

    logic [SIDE_W-1:0] side_eff;
    logic [TCNT_W-1:0] across_eff;
    logic [TCNT_W-1:0] down_eff;
    logic              accept;
    logic              col_end;
    logic              row_end;
    logic              tile_last_row;
    logic              frame_last_row;
    logic [SUM_W-1:0]  rdata;
    logic [SUM_W-1:0]  base;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum;

    always_comb begin
        if (i_cell_side == '0) begin
            side_eff = SIDE_W'(1);
        end else if (i_cell_side > SIDE_W'(MAX_SIDE)) begin
            side_eff = SIDE_W'(MAX_SIDE);
        end else begin
            side_eff = i_cell_side;
        end
        if (i_tiles_across == '0) begin
            across_eff = TCNT_W'(1);
        end else if (i_tiles_across > TCNT_W'(MAX_TILES)) begin
            across_eff = TCNT_W'(MAX_TILES);
        end else begin
            across_eff = i_tiles_across;
        end
        if (i_tiles_down == '0) begin
            down_eff = TCNT_W'(1);
        end else if (i_tiles_down > TCNT_W'(MAX_ROWS)) begin
            down_eff = TCNT_W'(MAX_ROWS);
        end else begin
            down_eff = i_tiles_down;
        end
    end

    // room for the word in flight and the one taken now
    assign o_full = i_q_count > QCNT_W'(QUEUE_DEPTH - 2);
    assign accept = i_push && !o_full;

    assign col_end        = (SIDE_W'(r_col) + SIDE_W'(1)) >= side_eff;
    assign row_end        = col_end && ((TCNT_W'(r_tcol) + TCNT_W'(1)) >= across_eff);
    assign tile_last_row  = (SIDE_W'(r_row) + SIDE_W'(1)) >= side_eff;
    assign frame_last_row = (TCNT_W'(r_trow) + TCNT_W'(1)) >= down_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_tcol     <= '0;
            r_row      <= '0;
            r_trow     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (!col_end) begin
                    r_col <= r_col + COL_W'(1);
                end else begin
                    r_col <= '0;
                    if (!row_end) begin
                        r_tcol <= r_tcol + SLOT_W'(1);
                    end else begin
                        r_tcol <= '0;
                        if (!tile_last_row) begin
                            r_row <= r_row + COL_W'(1);
                        end else begin
                            r_row  <= '0;
                            r_trow <= frame_last_row ? '0 : r_trow + SLOT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix        <= i_pixel;
            r_s1_slot       <= r_tcol;
            r_s1_first      <= (r_row == '0);
            r_s1_tile_end   <= col_end && tile_last_row;
            r_s1_row_end    <= row_end;
            r_s1_frame_last <= frame_last_row;
            r_s1_side       <= side_eff;
            // a write in this cycle is not yet seen by the read
            r_s1_fwd        <= r_s1_valid && (r_s1_slot == r_tcol);
            r_s1_fwd_sum    <= sum;
        end
    end

    tmar_ram #(
        .WIDTH (SUM_W),
        .DEPTH (TILE_SLOTS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_slot),
        .i_wdata (sum),
        .i_raddr (r_tcol),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_s1_first) begin
            base = '0;
        end else if (r_s1_fwd) begin
            base = r_s1_fwd_sum;
        end else begin
            base = rdata;
        end
        sum_wide = {1'b0, base} + (SUM_W + 1)'(r_s1_pix);
        sum      = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end

    assign o_q_push            = r_s1_valid && r_s1_tile_end;
    assign o_q_word.sum        = sum;
    assign o_q_word.side       = r_s1_side;
    assign o_q_word.row_end    = r_s1_row_end;
    assign o_q_word.frame_last = r_s1_frame_last;

endmodule

`default_nettype wire

// ===== design/tmar_fifo.sv =====
`default_nettype none

module tmar_fifo
    import tmar_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_tile_word        i_word,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output t_tile_word             o_word,
    output logic [QCNT_W-1:0]      o_count
);

    t_tile_word        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/tmar_back.sv =====
`default_nettype none

module tmar_back
    import tmar_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire t_tile_word        i_q_word,
    output logic                   o_q_pop,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [CHAR_W-1:0]      o_char_code,
    output logic                   o_run_last,
    output logic                   o_frame_done
);

    t_back_state       r_state;
    t_back_state       n_state;

    logic [SUM_W-1:0]  r_rem;
    logic [SIDE_W-1:0] r_side;
    logic [DVS_W-1:0]  r_dvs;
    logic              r_row_end;
    logic              r_frame_last;
    logic [MEAN_W-1:0] r_q;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_frame;

    logic              slot_free;
    logic              sat;
    logic [SUM_W:0]    shf;
    logic              ge;
    logic              out_load;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              out_frame;

    assign slot_free = !r_out_valid || i_pop;
    assign sat       = (SUM_W + 1)'(r_rem) >= ((SUM_W + 1)'(r_dvs) << MEAN_W);
    assign shf       = (SUM_W + 1)'(r_dvs) << r_step;
    assign ge        = (SUM_W + 1)'(r_rem) >= shf;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_SAT;
            ST_SAT:  n_state = sat ? ST_CHAR : ST_DIV;
            ST_DIV: begin
                if (r_step == '0) n_state = ST_CHAR;
            end
            ST_CHAR: begin
                if (slot_free) n_state = r_row_end ? ST_NL : ST_IDLE;
            end
            ST_NL: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        out_load  = 1'b0;
        out_char  = ramp_char(r_q);
        out_last  = !r_row_end;
        out_frame = 1'b0;
        unique case (r_state)
            ST_IDLE: o_q_pop = !i_q_empty;
            ST_CHAR: out_load = slot_free;
            ST_NL: begin
                out_load  = slot_free;
                out_char  = NEWLINE_CODE;
                out_last  = 1'b1;
                out_frame = r_frame_last;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem        <= i_q_word.sum;
            r_side       <= i_q_word.side;
            r_row_end    <= i_q_word.row_end;
            r_frame_last <= i_q_word.frame_last;
        end
        if (r_state == ST_LOAD) begin
            r_dvs <= DVS_W'(r_side) * DVS_W'(r_side);
        end
        if (r_state == ST_SAT) begin
            r_q    <= sat ? '1 : '0;
            r_step <= STEP_W'(MEAN_W - 1);
        end
        if (r_state == ST_DIV) begin
            if (ge) begin
                r_rem       <= r_rem - shf[SUM_W-1:0];
                r_q[r_step] <= 1'b1;
            end
            r_step <= r_step - STEP_W'(1);
        end
        if (out_load) begin
            r_out_char  <= out_char;
            r_out_last  <= out_last;
            r_out_frame <= out_frame;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_char_code  = r_out_char;
    assign o_run_last   = r_out_last;
    assign o_frame_done = r_out_frame;

endmodule

`default_nettype wire

// ===== design/tile_mean_to_ascii_ramp_top.sv =====
// Tile mean to ASCII ramp converter.
// Pixel channel: gray pixels in raster order, one word per push while full is low.
// Result channel: character words, oldest on the ports while empty is low, taken by pop.
// A tile's last pixel gives its ramp character; the last tile of a row also gives a
// newline (code 10), with frame_done set on the newline ending the frame.
// Config channel: cfg_valid/cfg_ready with index 0 cell_side, 1 tiles_across,
// 2 tiles_down; cfg_ready is always high, other indexes are ignored.
// Pixels are taken one per cycle while full is low: a read-modify-write of the column sum memory.
// Each finished tile goes through a 4-deep queue to the divide unit, which squares the
// side, skips the divide when the mean saturates and else finds the mean bit by bit.
// The divide loop sets the rate: with small tiles full rises until the queue drains.
// When the receiver stalls, results hold on the ports, the divide unit waits, and
// the queue then stops pixel intake through full.
// Reset clears counters, queue and result register and loads the register defaults
// 12, 100 and 56; the sum memory needs no clearing.
`default_nettype none

module tile_mean_to_ascii_ramp_top
    import tmar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [PIX_W-1:0]      i_gray_pixel,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [CHAR_W-1:0]          o_char_code,
    output logic                       o_run_last,
    output logic                       o_frame_done,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SIDE_W-1:0] r_cell_side;
    logic [TCNT_W-1:0] r_tiles_across;
    logic [TCNT_W-1:0] r_tiles_down;

    logic              q_push;
    t_tile_word        q_in;
    logic              q_pop;
    logic              q_empty;
    t_tile_word        q_out;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_side    <= SIDE_RESET;
            r_tiles_across <= ACROSS_RESET;
            r_tiles_down   <= DOWN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (i_cfg_index)
                REG_CELL_SIDE:    r_cell_side    <= i_cfg_data[SIDE_W-1:0];
                REG_TILES_ACROSS: r_tiles_across <= i_cfg_data;
                REG_TILES_DOWN:   r_tiles_down   <= i_cfg_data;
                default: begin
                    r_cell_side <= r_cell_side;
                end
            endcase
        end
    end

    tmar_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_pixel        (i_gray_pixel),
        .i_cell_side    (r_cell_side),
        .i_tiles_across (r_tiles_across),
        .i_tiles_down   (r_tiles_down),
        .i_q_count      (q_count),
        .o_q_push       (q_push),
        .o_q_word       (q_in)
    );

    tmar_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (q_out),
        .o_count (q_count)
    );

    tmar_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_word     (q_out),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_char_code  (o_char_code),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule

`default_nettype wire
